// ===== rtl/ppp_pkg.sv =====
// Package for the point to polyline projection block: payload and constants.
// Used by ppp_ctrl, ppp_datapath and point_to_polyline_projection.
`default_nettype none
package ppp_pkg;
   localparam int MaxNodes   = 64;
   localparam int CoordBits  = 24;
   localparam int WeightBits = 16;
   localparam int IdxBits    = $clog2(MaxNodes);
   localparam int CntBits    = 7;
   localparam int DistBits   = 50;
   localparam int DiffBits   = CoordBits + 1;
   localparam int ProdBits   = 2 * DiffBits;
   localparam int SumBits    = ProdBits + 2;

   localparam logic KindWrite = 1'b0;
   localparam logic KindQuery = 1'b1;

   typedef struct packed {
      logic                        kind;
      logic [5:0]                  node_index;
      logic signed [CoordBits-1:0] coord_x;
      logic signed [CoordBits-1:0] coord_y;
      logic signed [CoordBits-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [5:0]            segment_index;
      logic [WeightBits:0]   weight;
      logic [DistBits-1:0]   distance_sq;
      logic                  too_few_nodes;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_query;
      logic       diff;
      logic       dot_step;
      logic       prep_div;
      logic       div_step;
      logic       proj_step;
      logic       dist_step;
      logic       compare;
      logic [1:0] axis;
      logic [IdxBits-1:0] seg;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic weight_fixed;
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/ppp_datapath.sv =====
// Datapath of the point to polyline projection block: node memories, the
// dot-product, projection and square multipliers, a restoring divider and the
// best-segment registers. Depends on ppp_pkg.
`default_nettype none
module ppp_datapath (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire ppp_pkg::req_type  wr_item,
   input  wire ppp_pkg::cmd_type  cmd,
   input  wire logic              first,
   output ppp_pkg::sts_type       sts,
   output logic [5:0]             best_seg,
   output logic [ppp_pkg::WeightBits:0]  best_w,
   output logic [ppp_pkg::DistBits-1:0]  best_d
);
   localparam int CB = ppp_pkg::CoordBits;
   localparam int DB = ppp_pkg::DiffBits;
   localparam int PB = ppp_pkg::ProdBits;
   localparam int SB = ppp_pkg::SumBits;
   localparam int WB = ppp_pkg::WeightBits;
   localparam int DistBits_m1 = ppp_pkg::DistBits - 1;

   logic signed [CB-1:0] mem_x [ppp_pkg::MaxNodes];
   logic signed [CB-1:0] mem_y [ppp_pkg::MaxNodes];
   logic signed [CB-1:0] mem_z [ppp_pkg::MaxNodes];
   logic signed [CB-1:0] rdx_ff, rdy_ff, rdz_ff;
   logic [ppp_pkg::IdxBits-1:0] rd_addr;

   logic signed [CB-1:0] qx_ff, qy_ff, qz_ff;
   logic signed [CB-1:0] n0_ff [3];
   logic signed [DB-1:0] e_ff [3];
   logic signed [DB-1:0] p_ff [3];
   logic signed [SB-1:0] den_ff, num_ff;
   logic [SB-1:0]        rem_ff;
   logic [WB:0]          w_ff;
   logic [5:0]           best_seg_ff;
   logic [WB:0]          best_w_ff;
   logic [DistBits_m1:0] best_d_ff;

   // Reads alternate between node seg (axis 0) and node seg+1 (axis 1).
   always_comb begin
      rd_addr = cmd.seg + ppp_pkg::IdxBits'(cmd.axis[0]);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_item.node_index[ppp_pkg::IdxBits-1:0]] <= wr_item.coord_x;
         mem_y[wr_item.node_index[ppp_pkg::IdxBits-1:0]] <= wr_item.coord_y;
         mem_z[wr_item.node_index[ppp_pkg::IdxBits-1:0]] <= wr_item.coord_z;
      end
      rdx_ff <= mem_x[rd_addr];
      rdy_ff <= mem_y[rd_addr];
      rdz_ff <= mem_z[rd_addr];
   end

   // Shared multiplier operands.
   logic signed [DB-1:0] ma, mb;
   logic signed [PB-1:0] prod;
   logic signed [WB+1:0] wsig;
   logic signed [DB+WB+2:0] wprod;
   logic signed [DB+WB+2:0] wround;
   logic signed [DB+1:0] pt;
   logic signed [DB+2:0] dq;
   logic [SB-1:0]        two_r;
   logic [SB-1:0]        den_u;

   always_comb begin
      ma = e_ff[cmd.axis];
      mb = cmd.dot_step && first ? e_ff[cmd.axis] : p_ff[cmd.axis];
      prod = ma * mb;
      wsig = {1'b0, w_ff};
      wprod = wsig * e_ff[cmd.axis];
      wround = wprod + (DB+WB+3)'(1 << (WB - 1));
      pt = (DB+2)'(n0_ff[cmd.axis]) + (DB+2)'(wround >>> WB);
      dq = (DB+3)'(cmd.axis == 2'd0 ? qx_ff : cmd.axis == 2'd1 ? qy_ff : qz_ff)
           - (DB+3)'(pt);
      two_r = rem_ff << 1;
      den_u = SB'(den_ff);
   end

   logic signed [2*DB+5:0] sq;
   logic signed [DB+2:0]   dq_ff;
   logic [SB-1:0]          acc_d_ff;
   assign sq = dq_ff * dq_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         qx_ff <= wr_item.coord_x;
         qy_ff <= wr_item.coord_y;
         qz_ff <= wr_item.coord_z;
      end
      // diff: axis 0 has node seg registered, axis 1 node seg+1.
      if (cmd.diff) begin
         if (cmd.axis == 2'd0) begin
            n0_ff[0] <= rdx_ff;
            n0_ff[1] <= rdy_ff;
            n0_ff[2] <= rdz_ff;
            p_ff[0] <= DB'(qx_ff) - DB'(rdx_ff);
            p_ff[1] <= DB'(qy_ff) - DB'(rdy_ff);
            p_ff[2] <= DB'(qz_ff) - DB'(rdz_ff);
         end else begin
            e_ff[0] <= DB'(rdx_ff) - DB'(n0_ff[0]);
            e_ff[1] <= DB'(rdy_ff) - DB'(n0_ff[1]);
            e_ff[2] <= DB'(rdz_ff) - DB'(n0_ff[2]);
            den_ff <= '0;
            num_ff <= '0;
         end
      end
      // dot_step with first high accumulates e.e, otherwise p.e.
      if (cmd.dot_step) begin
         if (first) den_ff <= den_ff + SB'(prod);
         else       num_ff <= num_ff + SB'(prod);
      end
      if (cmd.prep_div) begin
         if (den_ff == '0 || num_ff <= 0) w_ff <= '0;
         else if (num_ff >= den_ff) w_ff <= (WB+1)'(1 << WB);
         else w_ff <= '0;
         rem_ff <= SB'(num_ff);
      end
      if (cmd.div_step) begin
         if (two_r >= den_u) begin
            rem_ff <= two_r - den_u;
            w_ff   <= {w_ff[WB-1:0], 1'b1};
         end else begin
            rem_ff <= two_r;
            w_ff   <= {w_ff[WB-1:0], 1'b0};
         end
      end
      if (cmd.proj_step) begin
         dq_ff <= dq;
         if (cmd.axis == 2'd0) acc_d_ff <= '0;
      end
      if (cmd.dist_step) acc_d_ff <= acc_d_ff + SB'(sq);
      if (cmd.compare) begin
         if (first || acc_d_ff[DistBits_m1:0] < best_d_ff) begin
            best_d_ff   <= acc_d_ff[DistBits_m1:0];
            best_w_ff   <= w_ff;
            best_seg_ff <= 6'(cmd.seg);
         end
      end
   end

   assign sts.den_zero     = (den_ff == '0) || (num_ff <= 0);
   assign sts.weight_fixed = sts.den_zero || (num_ff >= den_ff);
   assign best_seg = best_seg_ff;
   assign best_w   = best_w_ff;
   assign best_d   = best_d_ff;
endmodule
`default_nettype wire

// ===== rtl/ppp_ctrl.sv =====
// Controller of the point to polyline projection block: sequences the
// per-segment steps. Depends on ppp_pkg.
`default_nettype none
module ppp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [ppp_pkg::CntBits-1:0] cnt,
   input  wire ppp_pkg::sts_type  sts,
   output ppp_pkg::cmd_type       cmd,
   output logic                   first,
   output logic                   busy,
   output logic                   done
);
   typedef enum logic [3:0] {
      S_IDLE, S_RD0, S_RD1, S_D0, S_D1, S_DEN, S_NUM, S_PREP, S_DIV,
      S_PROJ, S_DIST, S_CMP
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [ppp_pkg::IdxBits-1:0] seg_ff, seg_in;
   logic [4:0] bit_ff, bit_in;
   logic first_seg_ff, first_seg_in;
   logic [ppp_pkg::IdxBits:0] last;

   always_comb begin
      last = (cnt > ppp_pkg::CntBits'(ppp_pkg::MaxNodes)) ?
             (ppp_pkg::IdxBits+1)'(ppp_pkg::MaxNodes - 2) :
             (ppp_pkg::IdxBits+1)'(cnt - 7'd2);
      state_in = state_ff; axis_in = axis_ff; seg_in = seg_ff; bit_in = bit_ff;
      first_seg_in = first_seg_ff;
      cmd = '0; cmd.seg = seg_ff; cmd.axis = axis_ff;
      first = 1'b0; done = 1'b0;
      case (state_ff)
         S_IDLE: if (go) begin
            seg_in = '0; first_seg_in = 1'b1; state_in = S_RD0;
         end
         // Each node read is registered, so a diff follows its own read.
         S_RD0: begin cmd.axis = 2'd0; state_in = S_D0; end
         S_D0: begin cmd.axis = 2'd0; cmd.diff = 1'b1; state_in = S_RD1; end
         S_RD1: begin cmd.axis = 2'd1; state_in = S_D1; end
         S_D1: begin
            cmd.axis = 2'd1; cmd.diff = 1'b1; axis_in = 2'd0; state_in = S_DEN;
         end
         S_DEN: begin
            cmd.dot_step = 1'b1; first = 1'b1;
            if (axis_ff == 2'd2) begin axis_in = 2'd0; state_in = S_NUM; end
            else axis_in = axis_ff + 2'd1;
         end
         S_NUM: begin
            cmd.dot_step = 1'b1;
            if (axis_ff == 2'd2) begin axis_in = 2'd0; state_in = S_PREP; end
            else axis_in = axis_ff + 2'd1;
         end
         S_PREP: begin
            cmd.prep_div = 1'b1; bit_in = '0;
            state_in = sts.weight_fixed ? S_PROJ : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_ff == 5'(ppp_pkg::WeightBits - 1)) state_in = S_PROJ;
            bit_in = bit_ff + 5'd1;
         end
         S_PROJ: begin cmd.proj_step = 1'b1; state_in = S_DIST; end
         S_DIST: begin
            cmd.dist_step = 1'b1;
            if (axis_ff == 2'd2) begin axis_in = 2'd0; state_in = S_CMP; end
            else begin axis_in = axis_ff + 2'd1; state_in = S_PROJ; end
         end
         S_CMP: begin
            cmd.compare = 1'b1; first = first_seg_ff; first_seg_in = 1'b0;
            if ({1'b0, seg_ff} == last) begin done = 1'b1; state_in = S_IDLE; end
            else begin seg_in = seg_ff + ppp_pkg::IdxBits'(1); state_in = S_RD0; end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; axis_ff <= '0; seg_ff <= '0; bit_ff <= '0;
         first_seg_ff <= 1'b0;
      end else begin
         state_ff <= state_in; axis_ff <= axis_in; seg_ff <= seg_in;
         bit_ff <= bit_in; first_seg_ff <= first_seg_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/point_to_polyline_projection.sv =====
// Nearest segment of a stored 3-D polyline to a query point.
// A query visits each segment of the stored polyline in turn, up to 63 segments for 64
// nodes; the 16-step restoring divider is skipped when the weight is clamped. busy is
// high while a query runs and while its result is shown.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous reset clears node_count and the controller; node memory is not cleared.
`default_nettype none
module point_to_polyline_projection (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ppp_pkg::req_type  req_item,
   output logic                   rsp_valid,
   output ppp_pkg::rsp_type       rsp_item,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [ppp_pkg::CntBits-1:0] csr_data
);
   logic [ppp_pkg::CntBits-1:0] node_count_ff;
   logic accept, go, first, ctrl_busy, done, rsp_valid_ff;
   ppp_pkg::cmd_type cmd, dcmd;
   ppp_pkg::sts_type sts;
   logic [5:0] best_seg;
   logic [ppp_pkg::WeightBits:0] best_w;
   logic [ppp_pkg::DistBits-1:0] best_d;
   logic few;

   assign accept = start && !busy;
   assign few = (node_count_ff < 7'd2);
   assign go = accept && (req_item.kind == ppp_pkg::KindQuery) && !few;
   assign csr_ready = 1'b1;

   always_comb begin
      dcmd = cmd;
      dcmd.load_query = go;
   end

   ppp_ctrl u_ctrl (
      .clock, .reset, .go, .cnt(node_count_ff), .sts, .cmd, .first,
      .busy(ctrl_busy), .done
   );

   ppp_datapath u_dp (
      .clock, .wr_en(accept && req_item.kind == ppp_pkg::KindWrite),
      .wr_item(req_item), .cmd(dcmd), .first, .sts, .best_seg, .best_w, .best_d
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) node_count_ff <= csr_data;
         rsp_valid_ff <= (accept && req_item.kind == ppp_pkg::KindQuery && few);
      end
   end

   logic done_d_ff;
   always_ff @(posedge clock) begin
      if (reset) done_d_ff <= 1'b0;
      else       done_d_ff <= done;
   end

   always_comb begin
      rsp_item = '0;
      if (done_d_ff) begin
         rsp_item.segment_index = best_seg;
         rsp_item.weight        = best_w;
         rsp_item.distance_sq   = best_d;
      end else begin
         rsp_item.too_few_nodes = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff || done_d_ff;
   assign busy = ctrl_busy || done_d_ff;

   assert property (@(posedge clock) disable iff (reset) !(rsp_valid_ff && done_d_ff))
      else $error("two results in one cycle");
   assert property (@(posedge clock) disable iff (reset) done |=> !ctrl_busy)
      else $error("controller busy after finishing");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.too_few_nodes |-> rsp_item.weight <= 17'h10000)
      else $error("weight above one");
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for point_to_polyline_projection.
// It loads polyline nodes and queries points, predicting each nearest-segment result
// internally. Depends on ppp_pkg and the point_to_polyline_projection RTL.
`timescale 1ns / 1ps
module testbench;
   localparam int WatchdogLimit = 20000;
   localparam longint unsigned WeightOne = 64'd1 << ppp_pkg::WeightBits;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   ppp_pkg::req_type    req_item = '0;
   logic                csr_valid = 1'b0;
   logic [ppp_pkg::CntBits-1:0]  csr_data = '0;
   logic                busy;
   logic                rsp_valid;
   ppp_pkg::rsp_type    rsp_item;
   logic                csr_ready;

   point_to_polyline_projection dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   longint      node_x [ppp_pkg::MaxNodes];
   longint      node_y [ppp_pkg::MaxNodes];
   longint      node_z [ppp_pkg::MaxNodes];
   bit          node_written [ppp_pkg::MaxNodes];
   int unsigned nodes_in_use = 0;
   ppp_pkg::rsp_type pending_results [$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          quiet_cycles = 0;
   bit          gaps_on = 1'b1;

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Restoring division as the block does it: num and den fit in 52 bits.
   function automatic longint unsigned segment_weight(input longint px, input longint py,
         input longint pz, input longint ex, input longint ey, input longint ez);
      longint den, num, r;
      longint unsigned w;
      den = ex * ex + ey * ey + ez * ez;
      num = px * ex + py * ey + pz * ez;
      w = 0;
      if (den == 0 || num <= 0) return 0;
      if (num >= den) return WeightOne;
      r = num;
      for (int b = 0; b < ppp_pkg::WeightBits; b++) begin
         w = w << 1;
         if (r >= den - r) begin
            r = r - (den - r);
            w = w | 1;
         end else begin
            r = r + r;
         end
      end
      return w;
   endfunction

   // The projected coordinate is rounded to the nearest integer, halves upward.
   function automatic longint axis_square(input longint q, input longint n, input longint e,
         input longint unsigned w);
      longint p, d;
      p = n + ((longint'(w) * e + 64'sd32768) >>> ppp_pkg::WeightBits);
      d = q - p;
      return d * d;
   endfunction

   function automatic ppp_pkg::rsp_type nearest_segment(input longint qx, input longint qy,
         input longint qz);
      ppp_pkg::rsp_type res;
      int unsigned cnt;
      longint ex, ey, ez, d, best_d;
      longint unsigned w;
      res = '0;
      best_d = 0;
      cnt = (nodes_in_use > ppp_pkg::MaxNodes) ? ppp_pkg::MaxNodes : nodes_in_use;
      if (cnt < 2) begin
         res.too_few_nodes = 1'b1;
         return res;
      end
      for (int j = 0; j + 1 < cnt; j++) begin
         ex = node_x[j+1] - node_x[j];
         ey = node_y[j+1] - node_y[j];
         ez = node_z[j+1] - node_z[j];
         w = segment_weight(qx - node_x[j], qy - node_y[j], qz - node_z[j], ex, ey, ez);
         d = axis_square(qx, node_x[j], ex, w) + axis_square(qy, node_y[j], ey, w)
           + axis_square(qz, node_z[j], ez, w);
         if (j == 0 || d < best_d) begin
            best_d = d;
            res.segment_index = j[5:0];
            res.weight = w[ppp_pkg::WeightBits:0];
            res.distance_sq = best_d[ppp_pkg::DistBits-1:0];
         end
      end
      return res;
   endfunction

   function automatic void apply_item(input ppp_pkg::req_type it);
      longint qx, qy, qz;
      qx = longint'(it.coord_x);
      qy = longint'(it.coord_y);
      qz = longint'(it.coord_z);
      if (it.kind == ppp_pkg::KindWrite) begin
         node_x[it.node_index] = qx;
         node_y[it.node_index] = qy;
         node_z[it.node_index] = qz;
         node_written[it.node_index] = 1'b1;
      end else begin
         pending_results = {pending_results, nearest_segment(qx, qy, qz)};
      end
   endfunction

   // Start may be left high so that the next item follows without a gap; any
   // other task lowers it first.
   task automatic send_item(input ppp_pkg::req_type it);
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      items_sent++;
      apply_item(it);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic write_node(input int idx, input int x, input int y, input int z);
      ppp_pkg::req_type it;
      it.kind = ppp_pkg::KindWrite;
      it.node_index = idx[5:0];
      it.coord_x = x[ppp_pkg::CoordBits-1:0];
      it.coord_y = y[ppp_pkg::CoordBits-1:0];
      it.coord_z = z[ppp_pkg::CoordBits-1:0];
      send_item(it);
   endtask

   task automatic query_point(input int x, input int y, input int z);
      ppp_pkg::req_type it;
      it.kind = ppp_pkg::KindQuery;
      it.node_index = 6'($urandom);
      it.coord_x = x[ppp_pkg::CoordBits-1:0];
      it.coord_y = y[ppp_pkg::CoordBits-1:0];
      it.coord_z = z[ppp_pkg::CoordBits-1:0];
      send_item(it);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_node_count(input int cnt);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= cnt[ppp_pkg::CntBits-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      nodes_in_use = cnt & 32'h7f;
   endtask

   function automatic int random_coord();
      int lo, hi;
      lo = -(1 << (ppp_pkg::CoordBits - 1));
      hi = (1 << (ppp_pkg::CoordBits - 1)) - 1;
      case ($urandom_range(0, 4))
         0: return int'($signed(24'($urandom)));
         1: return $urandom_range(0, 2000) - 1000;
         2: return $urandom_range(0, 1) ? hi : lo;
         default: return $urandom_range(0, 100) - 50;
      endcase
   endfunction

   task automatic test_too_few_nodes();
      set_node_count(0);
      query_point(1, 2, 3);
      set_node_count(1);
      write_node(0, 7, -7, 7);
      query_point(-100, 0, 100);
   endtask

   task automatic test_coordinate_extremes();
      int lo, hi;
      lo = -(1 << (ppp_pkg::CoordBits - 1));
      hi = (1 << (ppp_pkg::CoordBits - 1)) - 1;
      set_node_count(2);
      write_node(0, lo, lo, lo);
      write_node(1, hi, hi, hi);
      query_point(lo, lo, lo);
      query_point(hi, hi, hi);
      query_point(0, 0, 0);
      query_point(hi, lo, 0);
      query_point(lo, hi, hi);
   endtask

   // A zero-length first edge and two segments at equal distance.
   task automatic test_zero_edge_and_ties();
      set_node_count(3);
      write_node(0, 5, 5, 5);
      write_node(1, 5, 5, 5);
      write_node(2, 100, 5, 5);
      query_point(5, 5, 5);
      query_point(50, 9, 5);
      query_point(200, -3, 5);
   endtask

   task automatic test_random_phases();
      int cnt, used, n;
      while (items_sent < 270) begin
         if (items_sent > 230) gaps_on = 1'b0;
         case ($urandom_range(0, 9))
            0: cnt = $urandom_range(0, 1);
            1: cnt = $urandom_range(0, 1) ? 127 : ppp_pkg::MaxNodes;
            default: cnt = $urandom_range(2, 8);
         endcase
         used = (cnt > ppp_pkg::MaxNodes) ? ppp_pkg::MaxNodes : cnt;
         set_node_count(cnt);
         for (int i = 0; i < used; i++)
            if (!node_written[i] || $urandom_range(0, 3) == 0)
               write_node(i, random_coord(), random_coord(), random_coord());
         if ($urandom_range(0, 4) == 0)
            write_node($urandom_range(0, ppp_pkg::MaxNodes - 1), random_coord(),
                       random_coord(), random_coord());
         n = (used == ppp_pkg::MaxNodes) ? 2 : $urandom_range(3, 8);
         for (int k = 0; k < n; k++)
            query_point(random_coord(), random_coord(), random_coord());
      end
   endtask

   always @(posedge clock) begin
      ppp_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.segment_index !== want.segment_index)
               report_mismatch($sformatf("segment_index %0d, expected %0d",
                  rsp_item.segment_index, want.segment_index));
            if (rsp_item.weight !== want.weight)
               report_mismatch($sformatf("weight %0d, expected %0d",
                  rsp_item.weight, want.weight));
            if (rsp_item.distance_sq !== want.distance_sq)
               report_mismatch($sformatf("distance_sq %0d, expected %0d",
                  rsp_item.distance_sq, want.distance_sq));
            if (rsp_item.too_few_nodes !== want.too_few_nodes)
               report_mismatch($sformatf("too_few_nodes %0b, expected %0b",
                  rsp_item.too_few_nodes, want.too_few_nodes));
         end
      end
   end

   // A long query can hold busy without any traffic.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_too_few_nodes();
      test_coordinate_extremes();
      test_zero_edge_and_ties();
      test_random_phases();
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
